/* rtl/rfd_pkg.sv */
// Shared types and constants for the row finite-difference derivative block.
`default_nettype none
package rfd_pkg;

  localparam int COL_W       = 12;
  localparam int DERIV_W     = 32;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int ORDER_W     = 2;
  localparam int ROWLEN_W    = 13;
  localparam int SCALE_W     = 32;
  localparam int WIN_DEPTH   = 4;
  localparam int PUSH_MAX    = 4;
  localparam int PUSH_IDX_W  = 2;
  localparam int PUSH_CNT_W  = 3;
  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_IDX_W = 4;
  localparam int QUEUE_LVL_W = 5;
  localparam int SCALE_SHIFT = 17;
  localparam int MIN_ROW_LEN = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE     = 2'd3;

  localparam logic [ORDER_W-1:0]  ORDER_SECOND   = 2'd2;
  localparam logic [ORDER_W-1:0]  ACCURACY_FIRST = 2'd1;

  localparam logic [ORDER_W-1:0]  DERIV_RESET  = 2'd1;
  localparam logic [ORDER_W-1:0]  ACC_RESET    = 2'd2;
  localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = 13'd4096;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 32'd65536;

  typedef struct packed {
    logic second;
    logic acc_first;
  } stencil_mode_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             row_end;
    logic             last;
  } job_ctl_t;

endpackage
`default_nettype wire

/* rtl/rfd_cell.sv */
// One sample cell of the window chain.
`default_nettype none
module rfd_cell #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

/* rtl/rfd_stencil.sv */
// Stencil sums over the window and the list of jobs one sample releases.
`default_nettype none
module rfd_stencil #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int SUM_W        = 38,
  parameter int CNT_W        = 12
) (
  input  logic                                                   ev_valid,
  input  logic [CNT_W-1:0]                                       ev_k,
  input  logic                                                   ev_end,
  input  rfd_pkg::stencil_mode_t                                 mode,
  input  logic [rfd_pkg::WIN_DEPTH-1:0][SAMPLE_WIDTH-1:0]        win,
  output logic [rfd_pkg::PUSH_CNT_W-1:0]                         job_count,
  output logic [rfd_pkg::PUSH_MAX-1:0][SUM_W-1:0]                job_sums,
  output rfd_pkg::job_ctl_t [rfd_pkg::PUSH_MAX-1:0]              job_ctls
);
  import rfd_pkg::*;

  localparam int KX_W = (CNT_W > COL_W) ? CNT_W : COL_W;

  logic signed [SUM_W-1:0] x0, x1, x2, x3;
  logic signed [SUM_W-1:0] fwd_sum, bwd_sum, c2_sum, c1_sum;
  logic [KX_W-1:0]         kx, kx_m1;
  logic                    k_is3, k_gt3;

  // x0 is the newest sample, x3 the oldest
  assign x0 = SUM_W'(signed'(win[0]));
  assign x1 = SUM_W'(signed'(win[1]));
  assign x2 = SUM_W'(signed'(win[2]));
  assign x3 = SUM_W'(signed'(win[3]));

  // all coefficients doubled so every sum stays integral
  always_comb begin
    if (mode.second) begin
      fwd_sum = mode.acc_first ? ((x3 - (x2 <<< 1) + x1) <<< 1)
                               : (((x3 <<< 1) - ((x2 <<< 2) + x2) + (x1 <<< 2) - x0) <<< 1);
      bwd_sum = mode.acc_first ? ((x2 - (x1 <<< 1) + x0) <<< 1)
                               : (((x2 <<< 2) - x3 - ((x1 <<< 2) + x1) + (x0 <<< 1)) <<< 1);
      c2_sum  = (x3 - (x2 <<< 1) + x1) <<< 1;
      c1_sum  = (x2 - (x1 <<< 1) + x0) <<< 1;
    end else begin
      fwd_sum = mode.acc_first ? ((x2 - x3) <<< 1)
                               : ((x2 <<< 2) - ((x3 <<< 1) + x3) - x1);
      bwd_sum = mode.acc_first ? ((x0 - x1) <<< 1)
                               : (x2 - (x1 <<< 2) + ((x0 <<< 1) + x0));
      c2_sum  = x1 - x3;
      c1_sum  = x0 - x2;
    end
  end

  assign kx    = KX_W'(ev_k);
  assign kx_m1 = KX_W'(ev_k - CNT_W'(1));
  assign k_is3 = ev_valid && (ev_k == CNT_W'(3));
  assign k_gt3 = ev_valid && (ev_k > CNT_W'(3));

  always_comb begin
    job_count = '0;
    job_sums  = '0;
    job_ctls  = '0;
    if (k_is3) begin
      // column 3 arrives: first three columns of the row come out at once, column 3 too if it ends the row
      job_sums[0]        = fwd_sum;
      job_ctls[0].column = COL_W'(0);
      job_sums[1]        = c2_sum;
      job_ctls[1].column = COL_W'(1);
      job_sums[2]        = c1_sum;
      job_ctls[2].column = COL_W'(2);
      job_sums[3]         = bwd_sum;
      job_ctls[3].column  = kx[COL_W-1:0];
      job_ctls[3].row_end = 1'b1;
      job_count = ev_end ? PUSH_CNT_W'(4) : PUSH_CNT_W'(3);
    end else if (k_gt3) begin
      job_sums[0]         = c1_sum;
      job_ctls[0].column  = kx_m1[COL_W-1:0];
      job_sums[1]         = bwd_sum;
      job_ctls[1].column  = kx[COL_W-1:0];
      job_ctls[1].row_end = 1'b1;
      job_count = ev_end ? PUSH_CNT_W'(2) : PUSH_CNT_W'(1);
    end
    if (job_count != '0) begin
      job_ctls[PUSH_IDX_W'(job_count - PUSH_CNT_W'(1))].last = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/rfd_job_queue.sv */
// Job queue: up to four pushes and one pop per cycle.
`default_nettype none
module rfd_job_queue #(
  parameter int SUM_W = 38
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [rfd_pkg::PUSH_CNT_W-1:0]                push_count,
  input  logic [rfd_pkg::PUSH_MAX-1:0][SUM_W-1:0]       push_sums,
  input  rfd_pkg::job_ctl_t [rfd_pkg::PUSH_MAX-1:0]     push_ctls,
  input  logic                                          pop,
  output logic [rfd_pkg::QUEUE_LVL_W-1:0]               level,
  output logic [SUM_W-1:0]                              head_sum,
  output rfd_pkg::job_ctl_t                             head_ctl
);
  import rfd_pkg::*;

  logic [SUM_W-1:0]       sum_q [QUEUE_DEPTH];
  job_ctl_t               ctl_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wptr_r, wptr_nxt;
  logic [QUEUE_IDX_W-1:0] rptr_r, rptr_nxt;
  logic [QUEUE_LVL_W-1:0] level_r, level_nxt;

  assign wptr_nxt  = wptr_r + QUEUE_IDX_W'(push_count);
  assign rptr_nxt  = rptr_r + QUEUE_IDX_W'(pop);
  assign level_nxt = level_r + QUEUE_LVL_W'(push_count) - QUEUE_LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  // entry e takes push slot (e - wptr) when that slot is in use
  always_ff @(posedge clk) begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      logic [QUEUE_IDX_W-1:0] ofs;
      ofs = QUEUE_IDX_W'(e) - wptr_r;
      if (ofs < QUEUE_IDX_W'(push_count)) begin
        sum_q[e] <= push_sums[ofs[PUSH_IDX_W-1:0]];
        ctl_q[e] <= push_ctls[ofs[PUSH_IDX_W-1:0]];
      end
    end
  end

  assign level    = level_r;
  assign head_sum = sum_q[rptr_r];
  assign head_ctl = ctl_q[rptr_r];

endmodule
`default_nettype wire

/* rtl/rfd_scale.sv */
// Scale, round and saturate pipeline with the output register.
`default_nettype none
module rfd_scale #(
  parameter int SUM_W = 38
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SUM_W-1:0]              in_sum,
  input  rfd_pkg::job_ctl_t             in_ctl,
  input  logic [rfd_pkg::SCALE_W-1:0]   step_scale,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfd_pkg::DERIV_W-1:0]   out_deriv,
  output rfd_pkg::job_ctl_t             out_ctl
);
  import rfd_pkg::*;

  localparam int MAGX_W = (SUM_W > 33) ? SUM_W : 33;
  localparam int HI_W   = MAGX_W - 32;
  localparam int PROD_W = HI_W + 64;
  localparam int Q_W    = PROD_W - SCALE_SHIFT;

  logic                 adv1, adv2;
  logic                 neg;
  logic [SUM_W-1:0]     mag;
  logic [MAGX_W-1:0]    magx;
  logic [63:0]          lo_nxt;
  logic [HI_W+31:0]     hi_nxt;

  logic                 s1_v_r;
  logic                 s1_neg_r;
  logic [63:0]          s1_lo_r;
  logic [HI_W+31:0]     s1_hi_r;
  job_ctl_t             s1_ctl_r;

  logic [PROD_W-1:0]    prod, rounded;
  logic [Q_W-1:0]       q;
  logic [32:0]          limit;
  logic [31:0]          qs;
  logic [DERIV_W-1:0]   deriv_nxt;

  logic                 o_v_r;
  logic [DERIV_W-1:0]   o_deriv_r;
  job_ctl_t             o_ctl_r;

  assign adv2     = !o_v_r || out_ready;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  // sign and magnitude, then two partial products
  assign neg    = in_sum[SUM_W-1];
  assign mag    = neg ? (SUM_W'(0) - in_sum) : in_sum;
  assign magx   = MAGX_W'(mag);
  assign lo_nxt = magx[31:0] * step_scale;
  assign hi_nxt = magx[MAGX_W-1:32] * step_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_neg_r <= neg;
      s1_lo_r  <= lo_nxt;
      s1_hi_r  <= hi_nxt;
      s1_ctl_r <= in_ctl;
    end
  end

  // round half away from zero on the magnitude, clamp, restore sign
  assign prod    = {s1_hi_r, 32'd0} + PROD_W'(s1_lo_r);
  assign rounded = prod + PROD_W'(32'h0001_0000);
  assign q       = rounded[PROD_W-1:SCALE_SHIFT];
  assign limit   = s1_neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign qs      = (q > Q_W'(limit)) ? limit[31:0] : q[31:0];
  assign deriv_nxt = s1_neg_r ? (32'd0 - qs) : qs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv2) begin
      o_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      o_deriv_r <= deriv_nxt;
      o_ctl_r   <= s1_ctl_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_deriv = o_deriv_r;
  assign out_ctl   = o_ctl_r;

endmodule
`default_nettype wire

/* rtl/row_finite_difference_derivative.sv */
// Row finite-difference derivative: top level with window chain, job queue and scaler.
// Path: an accepted sample goes through the event register, job queue, scale stage and
//   output register; its further results follow one per cycle while out_tready is high.
// Throughput: one sample per cycle sustained while out_tready stays high; the single
//   result port and the 16-entry job queue set this (column 3 releases up to four jobs).
// Reset (rst_n low, synchronous): window cleared, column count zero, queue and pipeline
//   empty, registers back to first derivative, accuracy 2, row length 4096, scale 1.0.
`default_nettype none
module row_finite_difference_derivative #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int SAMPLE_WIDTH   = 32,
  localparam int IN_W          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample request: tdata = {pad, sample[SAMPLE_WIDTH-1:0]}
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_W-1:0]                    in_tdata,
  // result: tdata = {pad[47:44], column[43:32], derivative[31:0]}
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rfd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,   // row_end
  output logic [0:0]                         out_tuser,   // last result of the sample
  // configuration write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rfd_pkg::*;

  localparam int CNT_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int CMP_W = (CNT_W + 1 > ROWLEN_W) ? CNT_W + 1 : ROWLEN_W;
  localparam int SUM_W = SAMPLE_WIDTH + 6;

  // ---------------------------------------------------------------- config
  logic [ORDER_W-1:0]  deriv_order_r;
  logic [ORDER_W-1:0]  acc_order_r;
  logic [ROWLEN_W-1:0] row_len_r;
  logic [SCALE_W-1:0]  step_scale_r;
  logic                cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deriv_order_r <= DERIV_RESET;
      acc_order_r   <= ACC_RESET;
      row_len_r     <= ROWLEN_RESET;
      step_scale_r  <= SCALE_RESET;
    end else if (cfg_acc) begin
      case (cfg_addr)
        CFG_DERIV_ORDER:    deriv_order_r <= cfg_data[ORDER_W-1:0];
        CFG_ACCURACY_ORDER: acc_order_r   <= cfg_data[ORDER_W-1:0];
        CFG_ROW_LENGTH:     row_len_r     <= cfg_data[ROWLEN_W-1:0];
        CFG_STEP_SCALE:     step_scale_r  <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  stencil_mode_t mode;
  assign mode.second    = (deriv_order_r == ORDER_SECOND);
  assign mode.acc_first = (acc_order_r == ACCURACY_FIRST);

  // clamp the row length into [4, MAX_ROW_LENGTH] and find the last column
  logic [CMP_W-1:0] len_x, len_eff;
  logic [CNT_W-1:0] last_col;

  assign len_x = CMP_W'(row_len_r);
  always_comb begin
    if (len_x < CMP_W'(MIN_ROW_LEN)) begin
      len_eff = CMP_W'(MIN_ROW_LEN);
    end else if (len_x > CMP_W'(MAX_ROW_LENGTH)) begin
      len_eff = CMP_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = len_x;
    end
  end
  assign last_col = CNT_W'(len_eff - CMP_W'(1));

  // --------------------------------------------------------- input request
  logic                 in_acc;
  logic [CNT_W-1:0]     col_r, col_nxt;
  logic                 col_end;
  logic [QUEUE_LVL_W-1:0] q_level;

  // keep room for the job burst of the sample in flight plus this one
  assign in_tready = (q_level <= QUEUE_LVL_W'(QUEUE_DEPTH - 2 * PUSH_MAX));
  assign in_acc    = in_tvalid && in_tready;

  // a column at or past the last column closes the row
  assign col_end = (col_r >= last_col);
  assign col_nxt = col_end ? '0 : col_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
    end
  end

  // ------------------------------------------------------ window cell chain
  // cell 0 holds the newest sample; every accepted sample shifts the chain
  logic [WIN_DEPTH-1:0][SAMPLE_WIDTH-1:0] cell_d;
  logic [WIN_DEPTH-1:0][SAMPLE_WIDTH-1:0] win_q;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i] = in_tdata[SAMPLE_WIDTH-1:0];
    end else begin : g_link
      assign cell_d[i] = win_q[i-1];
    end
    rfd_cell #(
      .W (SAMPLE_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (in_acc),
      .d     (cell_d[i]),
      .q     (win_q[i])
    );
  end

  // ---------------------------------------------------------- event stage
  // the cycle after a request, the chain holds that sample's window
  logic             ev_valid_r;
  logic [CNT_W-1:0] ev_k_r;
  logic             ev_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    ev_k_r   <= col_r;
    ev_end_r <= col_end;
  end

  logic [PUSH_CNT_W-1:0]          job_count;
  logic [PUSH_MAX-1:0][SUM_W-1:0] job_sums;
  job_ctl_t [PUSH_MAX-1:0]        job_ctls;

  rfd_stencil #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W)
  ) u_stencil (
    .ev_valid  (ev_valid_r),
    .ev_k      (ev_k_r),
    .ev_end    (ev_end_r),
    .mode      (mode),
    .win       (win_q),
    .job_count (job_count),
    .job_sums  (job_sums),
    .job_ctls  (job_ctls)
  );

  // ------------------------------------------------------------- job queue
  logic             q_pop;
  logic [SUM_W-1:0] head_sum;
  job_ctl_t         head_ctl;
  logic             scale_ready;

  assign q_pop = (q_level != '0) && scale_ready;

  rfd_job_queue #(
    .SUM_W (SUM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (job_count),
    .push_sums  (job_sums),
    .push_ctls  (job_ctls),
    .pop        (q_pop),
    .level      (q_level),
    .head_sum   (head_sum),
    .head_ctl   (head_ctl)
  );

  // ------------------------------------------------- scale and result port
  logic [DERIV_W-1:0] out_deriv;
  job_ctl_t           out_ctl;

  rfd_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_level != '0),
    .in_ready   (scale_ready),
    .in_sum     (head_sum),
    .in_ctl     (head_ctl),
    .step_scale (step_scale_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_deriv  (out_deriv),
    .out_ctl    (out_ctl)
  );

  assign out_tdata = OUT_DATA_W'({out_ctl.column, out_deriv});
  assign out_tlast = out_ctl.row_end;
  assign out_tuser = out_ctl.last;

  // ------------------------------------------------------------ assertions
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QUEUE_LVL_W'(QUEUE_DEPTH))
    else $error("job queue overflow");

  a_row_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_end) |=> (col_r == '0))
    else $error("column count did not wrap at row end");

  a_jobs_need_window : assert property (@(posedge clk) disable iff (!rst_n)
    (job_count != '0) |-> (ev_valid_r && (ev_k_r >= CNT_W'(3))))
    else $error("jobs released before the window is full");

  a_row_end_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[0])
    else $error("row end result not marked as final of its sample");

endmodule
`default_nettype wire
